FILE: rtl/touch_swipe_classifier_assert.svh
// Assertion macros for the touch swipe classifier.
// Used inside touch_swipe_classifier; expects clk and rst_n in scope.
`ifndef TOUCH_SWIPE_CLASSIFIER_ASSERT_SVH
`define TOUCH_SWIPE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch_swipe_classifier: assertion failed");

// Next-cycle implication, checked out of reset.
`define TSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch_swipe_classifier: assertion failed");

`endif

FILE: rtl/tsc_pkg.sv
// Package for the touch swipe classifier: event codes, field widths, gesture type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

    localparam int TYPE_W  = 16;
    localparam int CODE_W  = 16;
    localparam int VALUE_W = 12;
    localparam int COORD_W = 12;
    localparam int THR_W   = 12;
    localparam int OUT_W   = 2;

    localparam logic [TYPE_W-1:0] TYPE_KEY   = 16'd1;
    localparam logic [TYPE_W-1:0] TYPE_ABS   = 16'd3;
    localparam logic [CODE_W-1:0] CODE_X     = 16'd0;
    localparam logic [CODE_W-1:0] CODE_Y     = 16'd1;
    localparam logic [CODE_W-1:0] CODE_TOUCH = 16'd330;

    localparam logic [VALUE_W-1:0] TOUCH_PRESS   = 12'd1;
    localparam logic [VALUE_W-1:0] TOUCH_RELEASE = 12'd0;

    // y*480/600 = y*4/5; floor(y*52429 / 2^16) is exact for 12-bit y
    localparam logic [15:0] Y_SCALE_RECIP = 16'd52429;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 12'd50;

    typedef enum logic [OUT_W-1:0] {
        GESTURE_NONE  = 2'd0,
        GESTURE_LEFT  = 2'd1,
        GESTURE_RIGHT = 2'd2
    } gesture_t;

endpackage

`default_nettype wire

FILE: rtl/touch_swipe_classifier.sv
// Touch swipe classifier top level: event decode, coordinate scaling, swipe decision.
// Depends on tsc_pkg and touch_swipe_classifier_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// Takes one touch event per transfer and returns one result per event, in order.
// X events (type 3, code 0) are scaled by 800/1024, Y events (type 3, code 1) by
// 480/600, truncating, and become the current point. A touch press (type 1,
// code 330, value 1) latches the current point as the start; a release (value 0)
// reports a left swipe (index up, wrapping at IMAGE_COUNT) when the start is right
// of the current point, else a right swipe (index down, wrapping), provided the
// horizontal travel exceeds both the vertical travel and the programmed threshold
// (thr_reg, loaded through cfg_wdata).
// Every other event reports no swipe and leaves the index as it was.
// Rate: one event per clock, sustained while result_stall is low. Each event
// passes through the input register, then the result register, with the
// scaling, compare and index step between the two.
// event_stall rises only when both registers are full and the result is stalled.
// The threshold port always takes the write (cfg_ready is tied high); write it
// only while no event is in flight.
module touch_swipe_classifier #(
    parameter int IMAGE_COUNT = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: swipe threshold
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tsc_pkg::THR_W-1:0]     cfg_wdata,
    // event input
    input  logic                          event_valid,
    output logic                          event_stall,
    input  logic [tsc_pkg::TYPE_W-1:0]    event_type,
    input  logic [tsc_pkg::CODE_W-1:0]    event_code,
    input  logic [tsc_pkg::VALUE_W-1:0]   event_value,
    // result output
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [tsc_pkg::OUT_W-1:0]     gesture,
    output logic [tsc_pkg::OUT_W-1:0]     image_index
);

    import tsc_pkg::*;

    localparam int IDX_W = (IMAGE_COUNT > 1) ? $clog2(IMAGE_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(IMAGE_COUNT - 1);

    // threshold register
    logic [THR_W-1:0]   thr_reg;

    // input stage
    logic               s1_valid_reg;
    logic [TYPE_W-1:0]  s1_type_reg;
    logic [CODE_W-1:0]  s1_code_reg;
    logic [VALUE_W-1:0] s1_value_reg;

    // tracked touch state
    logic [COORD_W-1:0] cur_x_reg;
    logic [COORD_W-1:0] cur_y_reg;
    logic [COORD_W-1:0] start_x_reg;
    logic [COORD_W-1:0] start_y_reg;
    logic [IDX_W-1:0]   sel_reg;
    logic [IDX_W-1:0]   sel_next;

    // result stage
    logic               res_valid_reg;
    gesture_t           res_gesture_reg;
    gesture_t           gest_next;
    logic [IDX_W-1:0]   res_index_reg;
    logic [IDX_W+1:0]   res_index_ext;

    // handshake
    logic               take_in;
    logic               adv;

    // decode and datapath
    logic               is_x;
    logic               is_y;
    logic               is_touch;
    logic               is_press;
    logic               is_release;
    logic [16:0]        x_prod;
    logic [27:0]        y_prod;
    logic [COORD_W-1:0] x_scaled;
    logic [COORD_W-1:0] y_scaled;
    logic [COORD_W-1:0] adx;
    logic [COORD_W-1:0] ady;
    logic               moved_left;
    logic               is_swipe;
    logic [IDX_W-1:0]   sel_up;
    logic [IDX_W-1:0]   sel_dn;

    // ------------------------------------------------------------------
    // Flow control: the result register frees when it is empty or taken;
    // the input register moves into it whenever it frees.
    // ------------------------------------------------------------------
    assign adv         = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign event_stall = s1_valid_reg && res_valid_reg && result_stall;
    assign take_in     = event_valid && !event_stall;
    assign cfg_ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take_in)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_type_reg  <= event_type;
            s1_code_reg  <= event_code;
            s1_value_reg <= event_value;
        end
    end

    // ------------------------------------------------------------------
    // Event decode
    // ------------------------------------------------------------------
    assign is_x       = (s1_type_reg == TYPE_ABS) && (s1_code_reg == CODE_X);
    assign is_y       = (s1_type_reg == TYPE_ABS) && (s1_code_reg == CODE_Y);
    assign is_touch   = (s1_type_reg == TYPE_KEY) && (s1_code_reg == CODE_TOUCH);
    assign is_press   = is_touch && (s1_value_reg == TOUCH_PRESS);
    assign is_release = is_touch && (s1_value_reg == TOUCH_RELEASE);

    // x*800/1024 = x*25/32: shift-add, then drop five bits
    assign x_prod   = {s1_value_reg, 4'b0000} + {1'b0, s1_value_reg, 3'b000}
                    + {5'b00000, s1_value_reg};
    assign x_scaled = x_prod[16:5];

    // y*4/5 by reciprocal
    assign y_prod   = {16'b0, s1_value_reg} * {12'b0, Y_SCALE_RECIP};
    assign y_scaled = y_prod[27:16];

    // ------------------------------------------------------------------
    // Swipe decision on release
    // ------------------------------------------------------------------
    assign moved_left = cur_x_reg < start_x_reg;
    assign adx = moved_left ? (start_x_reg - cur_x_reg) : (cur_x_reg - start_x_reg);
    assign ady = (cur_y_reg >= start_y_reg) ? (cur_y_reg - start_y_reg)
                                            : (start_y_reg - cur_y_reg);
    assign is_swipe = is_release && (adx > ady) && (adx > thr_reg);

    assign sel_up = (sel_reg == LAST_IDX) ? '0 : sel_reg + 1'b1;
    assign sel_dn = (sel_reg == '0) ? LAST_IDX : sel_reg - 1'b1;

    always_comb
    begin
        gest_next = GESTURE_NONE;
        sel_next  = sel_reg;
        if (is_swipe)
        begin
            if (moved_left)
            begin
                gest_next = GESTURE_LEFT;
                sel_next  = sel_up;
            end
            else
            begin
                gest_next = GESTURE_RIGHT;
                sel_next  = sel_dn;
            end
        end
    end

    // State changes take effect as the event moves into the result register,
    // so the next event in the input register already sees them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            sel_reg     <= '0;
        end
        else if (adv)
        begin
            if (is_x)
            begin
                cur_x_reg <= x_scaled;
            end
            if (is_y)
            begin
                cur_y_reg <= y_scaled;
            end
            if (is_press)
            begin
                start_x_reg <= cur_x_reg;
                start_y_reg <= cur_y_reg;
            end
            sel_reg <= sel_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_gesture_reg <= gest_next;
            res_index_reg   <= sel_next;
        end
    end

    assign res_index_ext = {2'b00, res_index_reg};
    assign result_valid  = res_valid_reg;
    assign gesture       = res_gesture_reg;
    assign image_index   = res_index_ext[1:0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "touch_swipe_classifier_assert.svh"

    `TSC_ASSERT_NOW(a_sel_in_range, 1'b1, sel_reg <= LAST_IDX)
    `TSC_ASSERT_NEXT(a_swipe_moves_index, adv && (gest_next != GESTURE_NONE), sel_reg != $past(sel_reg))
    `TSC_ASSERT_NEXT(a_no_swipe_keeps_index, adv && (gest_next == GESTURE_NONE), $stable(sel_reg))

endmodule

`default_nettype wire
